@@ hdl/msort_pkg.sv @@
// shared types and constants of the merge sorter
package msort_pkg;

  // width of one sorted value
  localparam int DATA_W = 32;

  // number of cells in the chain, i.e. the buffer capacity
  localparam int MAX_ITEMS = 64;

  // width of the fill counter, able to hold MAX_ITEMS itself
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0] count_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } ctl_t;

endpackage

@@ hdl/msort_cell.sv @@
// one cell of the sorting chain: holds one value and its occupancy bit
module msort_cell import msort_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  ctl_t  ctl,
  input  data_t x,
  input  logic  prev_gt,
  input  data_t prev_val,
  input  logic  prev_vld,
  input  data_t next_val,
  input  logic  next_vld,
  output logic  gt,
  output data_t val,
  output logic  vld
);

  data_t val_r, val_nxt;
  logic  vld_r, vld_nxt;

  // an empty cell counts as greater than anything; strict compare keeps ties in order
  assign gt = !vld_r || (val_r > x);

  // insert: make room by taking the left neighbour, or take the new value at the boundary
  // shift: pass contents towards the output end
  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (ctl.shift) begin
      val_nxt = next_val;
      vld_nxt = next_vld;
    end else if (ctl.insert && gt) begin
      if (prev_gt) begin
        val_nxt = prev_val;
        vld_nxt = prev_vld;
      end else begin
        val_nxt = x;
        vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign vld = vld_r;

endmodule

@@ hdl/msort_ctrl.sv @@
// sequencer: load and emit phases, fill count and overflow flag
module msort_ctrl import msort_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic in_last,
  output logic busy,
  output ctl_t ctl,
  output logic out_valid,
  output logic out_last_out,
  output logic out_overflow
);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;
  localparam count_t MAX_CNT = CNT_W'(MAX_ITEMS);
  localparam count_t ONE_CNT = CNT_W'(1);

  logic   state_r, state_nxt;
  count_t count_r, count_nxt;
  logic   dropped_r, dropped_nxt;
  logic   accept;
  logic   room;

  assign busy   = (state_r == ST_EMIT);
  assign accept = start && !busy;
  assign room   = (count_r < MAX_CNT);

  // broadcast to the cells
  assign ctl.insert = accept && room;
  assign ctl.shift  = (state_r == ST_EMIT);

  // phase and count update
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (room) begin
            count_nxt = count_r + ONE_CNT;
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        count_nxt = count_r - ONE_CNT;
        if (count_r == ONE_CNT) begin
          state_nxt   = ST_LOAD;
          dropped_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // result strobe and markers
  assign out_valid    = (state_r == ST_EMIT);
  assign out_last_out = (state_r == ST_EMIT) && (count_r == ONE_CNT);
  assign out_overflow = dropped_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("fill count beyond capacity");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_out |=> (state_r == ST_LOAD) && (count_r == '0) && !dropped_r)
    else $error("run not cleared after final transfer");

  a_last_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> busy && (count_r != '0))
    else $error("final item did not start an emit phase");

  a_load_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && room) |=> (count_r == $past(count_r) + ONE_CNT))
    else $error("stored item not counted");
`endif

endmodule

@@ hdl/merge_sorter_unit.sv @@
// top level of the sorter: sequencer and chain of insertion cells
//
// Sorts runs of signed 32-bit values into ascending order, stably.
// Input: an item (in_value, in_last) transfers at a rising edge with start
// high and busy low. While loading, one item is taken every cycle; each is
// inserted into a chain of MAX_ITEMS cells as it transfers, every cell comparing
// against the new value and passing its content to its neighbour.
// Items arriving with the chain full are dropped and flag the run as overflow.
// An item with in_last high ends the run; busy then rises until every value
// held has been shown, one result per cycle, the first in the cycle right
// after the final item transfer.
// Output: out_valid marks each result for exactly one cycle; it transfers at
// the edge ending that cycle and the receiver cannot hold it off.
// out_last_out marks the final result, out_overflow is high on every
// result of a run that dropped items. Results leave one at a time through
// the single output end of the chain. Reset (synchronous, rst_n low)
// empties the chain and returns to loading.
module merge_sorter_unit import msort_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  data_t in_value,
  input  logic  in_last,
  output logic  out_valid,
  output data_t out_sorted_value,
  output logic  out_last_out,
  output logic  out_overflow
);

  ctl_t  ctl;
  data_t cell_val [MAX_ITEMS];
  logic  cell_vld [MAX_ITEMS];
  logic  cell_gt  [MAX_ITEMS];

  // sequencer
  msort_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_last      (in_last),
    .busy         (busy),
    .ctl          (ctl),
    .out_valid    (out_valid),
    .out_last_out (out_last_out),
    .out_overflow (out_overflow)
  );

  // chain of cells, cell 0 at the output end
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic  prev_gt;
    data_t prev_val;
    logic  prev_vld;
    data_t next_val;
    logic  next_vld;

    if (i == 0) begin : g_first
      assign prev_gt  = 1'b0;
      assign prev_val = '0;
      assign prev_vld = 1'b0;
    end else begin : g_inner_prev
      assign prev_gt  = cell_gt[i-1];
      assign prev_val = cell_val[i-1];
      assign prev_vld = cell_vld[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_end
      assign next_val = '0;
      assign next_vld = 1'b0;
    end else begin : g_inner_next
      assign next_val = cell_val[i+1];
      assign next_vld = cell_vld[i+1];
    end

    msort_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .x        (in_value),
      .prev_gt  (prev_gt),
      .prev_val (prev_val),
      .prev_vld (prev_vld),
      .next_val (next_val),
      .next_vld (next_vld),
      .gt       (cell_gt[i]),
      .val      (cell_val[i]),
      .vld      (cell_vld[i])
    );
  end

  // results leave from the head of the chain
  assign out_sorted_value = cell_val[0];

`ifndef SYNTH
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cell_vld[0])
    else $error("result transfer from an empty cell");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_out) |-> (cell_vld[1] && (cell_val[0] <= cell_val[1])))
    else $error("chain head out of order");
`endif

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench for the merge sorter unit
`timescale 1ns / 100ps

module testbench;
  import msort_pkg::*;

  // one sorted value as it should leave the block
  typedef struct {
    data_t value;
    logic  last_out;
    logic  overflow;
  } sorted_t;

  // one row of the directed table; known rows carry their own answer
  typedef struct {
    data_t value;
    logic  last;
    bit    known;
    data_t known_value;
  } stim_row_t;

  localparam int NUM_ROWS = 19;
  localparam int ITEM_TARGET = 350;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  data_t in_value;
  logic  in_last;
  logic  out_valid;
  data_t out_sorted_value;
  logic  out_last_out;
  logic  out_overflow;

  // sorting model state and expected results
  data_t   held_values[$];
  logic    run_dropped;
  sorted_t sorted_run[$];
  sorted_t pending_sorted[$];

  int mismatches;
  int items_sent;

  stim_row_t directed_rows [NUM_ROWS] = '{
    // single-value runs at the extremes and around zero
    '{32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000},
    '{32'sh7FFF_FFFF, 1'b1, 1'b1, 32'sh7FFF_FFFF},
    '{32'sh0000_0000, 1'b1, 1'b1, 32'sh0000_0000},
    '{32'shFFFF_FFFF, 1'b1, 1'b1, 32'shFFFF_FFFF},
    // both extremes, largest first and smallest last, with values around zero between
    '{32'sh7FFF_FFFF, 1'b0, 1'b0, '0},
    '{32'sh0000_0000, 1'b0, 1'b0, '0},
    '{32'sh0000_0001, 1'b0, 1'b0, '0},
    '{32'shFFFF_FFFF, 1'b0, 1'b0, '0},
    '{32'sh8000_0000, 1'b1, 1'b0, '0},
    // equal values mixed with a negative one
    '{32'sh0000_0003, 1'b0, 1'b0, '0},
    '{32'shFFFF_FFFD, 1'b0, 1'b0, '0},
    '{32'sh0000_0003, 1'b0, 1'b0, '0},
    '{32'sh0000_0003, 1'b1, 1'b0, '0},
    // alternating bit patterns
    '{32'sh5555_5555, 1'b0, 1'b0, '0},
    '{32'shAAAA_AAAA, 1'b1, 1'b0, '0},
    // already in order
    '{32'sh8000_0000, 1'b0, 1'b0, '0},
    '{32'sh8000_0001, 1'b0, 1'b0, '0},
    '{32'sh7FFF_FFFE, 1'b0, 1'b0, '0},
    '{32'sh7FFF_FFFF, 1'b1, 1'b0, '0}
  };

  merge_sorter_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // print one line per mismatch, up to a cap, and count them all
  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // load one value; on the last one sort the run stably and list its results
  task automatic load_and_sort(input data_t v, input logic l);
    data_t key;
    int    j;
    sorted_t res;
    sorted_run.delete();
    if (held_values.size() < MAX_ITEMS) held_values.push_back(v);
    else run_dropped = 1'b1;
    if (l) begin
      // insertion sort keeps equal values in arrival order
      for (int i = 1; i < held_values.size(); i++) begin
        key = held_values[i];
        j = i - 1;
        while (j >= 0 && held_values[j] > key) begin
          held_values[j + 1] = held_values[j];
          j--;
        end
        held_values[j + 1] = key;
      end
      foreach (held_values[k]) begin
        res.value    = held_values[k];
        res.last_out = (k == held_values.size() - 1);
        res.overflow = run_dropped;
        sorted_run.push_back(res);
      end
      held_values.delete();
      run_dropped = 1'b0;
    end
  endtask

  // offer one item and wait for its transfer, then record what it should produce
  task automatic send_item(input data_t v, input logic l, input bit known, input data_t kv);
    sorted_t res;
    bit      idle_ok;
    idle_ok = !(items_sent >= 120 && items_sent < 220);
    if (idle_ok && $urandom_range(99) < 4) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_value <= v;
    in_last  <= l;
    start    <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    load_and_sort(v, l);
    if (known && l) begin
      res.value    = kv;
      res.last_out = 1'b1;
      res.overflow = 1'b0;
      pending_sorted.push_back(res);
    end else begin
      foreach (sorted_run[k]) pending_sorted.push_back(sorted_run[k]);
    end
  endtask

  // random value: full range, ties in a narrow band, or near the extremes
  function automatic data_t pick_value();
    case ($urandom_range(9))
      5, 6, 7: return data_t'($signed($urandom_range(6)) - 3);
      8:       return $urandom_range(1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      9:       return $urandom_range(1) ? data_t'(32'sh8000_0000 + $urandom_range(3))
                                        : data_t'(32'sh7FFF_FFFF - $urandom_range(3));
      default: return data_t'($urandom());
    endcase
  endfunction

  // compare every result transfer against the oldest expectation
  always @(posedge clk) begin : check_results
    sorted_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_sorted.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected", out_sorted_value));
      end else begin
        want = pending_sorted.pop_front();
        if (out_sorted_value !== want.value)
          report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                    out_sorted_value, want.value));
        if (out_last_out !== want.last_out)
          report_mismatch($sformatf("last_out %b, expected %b", out_last_out, want.last_out));
        if (out_overflow !== want.overflow)
          report_mismatch($sformatf("overflow %b, expected %b", out_overflow, want.overflow));
      end
    end
  end

  // stimulus and end of run
  initial begin : main_flow
    int run_len;
    int run_idx;
    mismatches  = 0;
    items_sent  = 0;
    run_dropped = 1'b0;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_value <= '0;
    in_last  <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int r = 0; r < NUM_ROWS; r++)
      send_item(directed_rows[r].value, directed_rows[r].last,
                directed_rows[r].known, directed_rows[r].known_value);

    // random runs; the first ones fill the buffer exactly, drop the last item, drop several
    run_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      case (run_idx)
        0:       run_len = MAX_ITEMS;
        1:       run_len = MAX_ITEMS + 1;
        2:       run_len = MAX_ITEMS + 6;
        default: begin
          case ($urandom_range(19))
            0, 1, 2:    run_len = $urandom_range(MAX_ITEMS + 4, MAX_ITEMS - 2);
            3, 4, 5:    run_len = $urandom_range(40, 9);
            default:    run_len = $urandom_range(8, 1);
          endcase
        end
      endcase
      for (int i = 0; i < run_len; i++)
        send_item(pick_value(), (i == run_len - 1), 1'b0, '0);
      run_idx++;
    end
    start <= 1'b0;

    // drain, then watch for stray results
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (MAX_ITEMS + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ merge_sorter_unit.f @@
hdl/msort_pkg.sv
hdl/msort_cell.sv
hdl/msort_ctrl.sv
hdl/merge_sorter_unit.sv
tb/sv/testbench.sv
